// File: hw/rtl/lwbc_pkg.sv
package lwbc_pkg;

  localparam int unsigned DefEntries   = 16;
  localparam int unsigned DefDataWidth = 64;
  localparam int unsigned BlkW         = 32;
  localparam int unsigned InDataW      = 64;

  typedef enum logic [1:0] {
    MODE_GET   = 2'd0,
    MODE_PUT   = 2'd1,
    MODE_INVAL = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_MISS     = 2'd1,
    ST_WB       = 2'd2,
    ST_NO_DIRTY = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the request
    logic exec;      // apply a get, put or invalidate
    logic fl_step;   // examine the flush rank, emit if dirty
    logic fl_none;   // emit the nothing-dirty result
    logic out_pop;   // output register taken
  } lwbc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_flush;
    logic fl_done;   // rank walk at its end
    logic fl_any;    // some writeback emitted in this flush
    logic out_full;
  } lwbc_sts_t;

endpackage

// File: hw/rtl/lwbc_datapath.sv
module lwbc_datapath
  import lwbc_pkg::*;
#(
  parameter int unsigned Entries   = DefEntries,
  parameter int unsigned DataWidth = DefDataWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lwbc_cmd_t           cmd_i,
  output lwbc_sts_t           sts_o,
  input  logic [1:0]          mode_i,
  input  logic [BlkW-1:0]     block_number_i,
  input  logic [InDataW-1:0]  write_data_i,
  input  logic                dirty_flag_i,
  output logic [1:0]          status_o,
  output logic [InDataW-1:0]  read_data_o,
  output logic [BlkW-1:0]     out_block_o,
  output logic                evicted_dirty_o,
  output logic                evicted_valid_o,
  output logic                last_o,
  output logic [31:0]         hit_total_o,
  output logic [31:0]         miss_total_o
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);

  // Entry storage
  logic [Entries-1:0]               valid_q, valid_d;
  logic [Entries-1:0]               dirty_q, dirty_d;
  logic [BlkW-1:0]                  tag_q   [Entries];
  logic [DataWidth-1:0]             data_q  [Entries];
  logic [IdxW-1:0]                  rank_q  [Entries];
  logic [IdxW-1:0]                  rank_d  [Entries];

  logic [1:0]           mode_q;
  logic [BlkW-1:0]      blk_q;
  logic [DataWidth-1:0] wdata_q;
  logic                 dflag_q;
  logic [31:0]          hits_q, misses_q;
  logic [CntW-1:0]      frank_q;
  logic                 fany_q;

  // Output register
  logic                 ofull_q;
  logic [1:0]           ostat_q;
  logic [DataWidth-1:0] odata_q;
  logic [BlkW-1:0]      oblk_q;
  logic                 oed_q, oev_q, olast_q;

  // Parallel match, free, LRU and flush-rank search
  logic [Entries-1:0] hit_vec, rank_vec;
  logic               hit, has_free, fl_hit;
  logic [IdxW-1:0]    hit_idx, free_idx, lru_idx, fl_idx;

  always_comb begin
    hit = 1'b0; hit_idx = '0;
    has_free = 1'b0; free_idx = '0;
    lru_idx = '0;
    fl_hit = 1'b0; fl_idx = '0;
    for (int i = 0; i < Entries; i++) begin
      hit_vec[i]  = valid_q[i] && (tag_q[i] == blk_q);
      rank_vec[i] = valid_q[i] && (CntW'(rank_q[i]) == frank_q);
    end
    for (int i = Entries - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin hit = 1'b1; hit_idx = IdxW'(i); end
      if (!valid_q[i]) begin has_free = 1'b1; free_idx = IdxW'(i); end
      if (rank_vec[i]) begin fl_hit = 1'b1; fl_idx = IdxW'(i); end
    end
    // when full the ranks are a permutation: LRU holds rank Entries-1
    for (int i = 0; i < Entries; i++) begin
      if (rank_q[i] == IdxW'(Entries - 1)) lru_idx = IdxW'(i);
    end
  end

  logic [IdxW-1:0] sel;
  logic [IdxW-1:0] sel_rank;
  always_comb begin
    sel = hit ? hit_idx : (has_free ? free_idx : lru_idx);
    sel_rank = rank_q[sel];
  end

  // Next-state of ranks, valid and dirty for the executed request
  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    for (int i = 0; i < Entries; i++) rank_d[i] = rank_q[i];
    if (cmd_i.exec) begin
      case (mode_q)
        MODE_GET, MODE_PUT: begin
          if (hit || !has_free || mode_q == MODE_GET) begin
            if (hit || mode_q == MODE_PUT) begin
              for (int i = 0; i < Entries; i++)
                if (valid_q[i] && IdxW'(i) != sel && rank_q[i] < sel_rank)
                  rank_d[i] = rank_q[i] + 1'b1;
              rank_d[sel] = '0;
            end
          end else begin
            for (int i = 0; i < Entries; i++)
              if (valid_q[i]) rank_d[i] = rank_q[i] + 1'b1;
            rank_d[sel] = '0;
          end
          if (mode_q == MODE_PUT) begin
            valid_d[sel] = 1'b1;
            dirty_d[sel] = hit ? (dirty_q[sel] | dflag_q) : dflag_q;
          end
        end
        MODE_INVAL: begin
          if (hit) begin
            for (int i = 0; i < Entries; i++)
              if (valid_q[i] && IdxW'(i) != sel && rank_q[i] > sel_rank)
                rank_d[i] = rank_q[i] - 1'b1;
            rank_d[sel]  = '0;
            valid_d[sel] = 1'b0;
            dirty_d[sel] = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.fl_step && fl_hit) begin
      dirty_d[fl_idx] = 1'b0;
    end
  end

  logic fl_emit;
  assign fl_emit = cmd_i.fl_step && fl_hit && dirty_q[fl_idx];

  // Last flag of a flush is only known once the walk ends: look ahead
  logic more_dirty;
  always_comb begin
    more_dirty = 1'b0;
    for (int i = 0; i < Entries; i++)
      if (valid_q[i] && dirty_q[i] && (CntW'(rank_q[i]) > frank_q)) more_dirty = 1'b1;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      dirty_q  <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      ofull_q  <= 1'b0;
      frank_q  <= '0;
      fany_q   <= 1'b0;
      mode_q   <= MODE_GET;
      for (int i = 0; i < Entries; i++) rank_q[i] <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      for (int i = 0; i < Entries; i++) rank_q[i] <= rank_d[i];
      if (cmd_i.load) begin
        mode_q  <= mode_i;
        frank_q <= '0;
        fany_q  <= 1'b0;
      end
      if (cmd_i.fl_step) begin
        frank_q <= frank_q + 1'b1;
        if (fl_emit) fany_q <= 1'b1;
      end
      if (cmd_i.exec && mode_q == MODE_GET) begin
        if (hit) hits_q <= hits_q + 32'd1;
        else     misses_q <= misses_q + 32'd1;
      end
      if (cmd_i.exec || fl_emit || cmd_i.fl_none) ofull_q <= 1'b1;
      else if (cmd_i.out_pop) ofull_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      blk_q   <= block_number_i;
      wdata_q <= write_data_i[DataWidth-1:0];
      dflag_q <= dirty_flag_i;
    end
    if (cmd_i.exec && mode_q == MODE_PUT) begin
      tag_q[sel]  <= blk_q;
      data_q[sel] <= wdata_q;
    end
    if (cmd_i.exec) begin
      odata_q <= '0;
      oed_q   <= 1'b0;
      oev_q   <= 1'b0;
      olast_q <= 1'b1;
      oblk_q  <= '0;
      ostat_q <= ST_DONE;
      case (mode_q)
        MODE_GET: begin
          if (hit) begin
            odata_q <= data_q[sel];
            oblk_q  <= tag_q[sel];
          end else begin
            ostat_q <= ST_MISS;
          end
        end
        MODE_PUT: begin
          if (!hit && !has_free) begin
            oblk_q <= tag_q[sel];
            oed_q  <= dirty_q[sel];
            oev_q  <= 1'b1;
          end
        end
        MODE_INVAL: begin
          oblk_q <= blk_q;
          if (!hit) ostat_q <= ST_MISS;
        end
        default: ;
      endcase
    end else if (fl_emit) begin
      ostat_q <= ST_WB;
      odata_q <= data_q[fl_idx];
      oblk_q  <= tag_q[fl_idx];
      oed_q   <= 1'b0;
      oev_q   <= 1'b0;
      olast_q <= !more_dirty;
    end else if (cmd_i.fl_none) begin
      ostat_q <= ST_NO_DIRTY;
      odata_q <= '0;
      oblk_q  <= '0;
      oed_q   <= 1'b0;
      oev_q   <= 1'b0;
      olast_q <= 1'b1;
    end
  end

  assign sts_o.is_flush = (mode_q == MODE_FLUSH);
  assign sts_o.fl_done  = (frank_q == CntW'(Entries - 1)) || !more_dirty;
  assign sts_o.fl_any   = fany_q;
  assign sts_o.out_full = ofull_q;

  assign status_o        = ostat_q;
  assign read_data_o     = InDataW'(odata_q);
  assign out_block_o     = oblk_q;
  assign evicted_dirty_o = oed_q;
  assign evicted_valid_o = oev_q;
  assign last_o          = olast_q;
  assign hit_total_o     = hits_q;
  assign miss_total_o    = misses_q;

endmodule

// File: hw/rtl/lwbc_ctrl.sv
module lwbc_ctrl
  import lwbc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  lwbc_sts_t sts_i,
  output lwbc_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_WAIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   pop;

  assign out_valid_o = sts_i.out_full;
  assign pop         = sts_i.out_full && out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_pop = pop;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      // Wait for the output register before writing a result
      S_EXEC: begin
        if (!sts_i.out_full || pop) begin
          if (sts_i.is_flush) begin
            state_d = S_FLUSH;
          end else begin
            cmd_o.exec = 1'b1;
            state_d    = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (!sts_i.out_full || pop) begin
          cmd_o.fl_step = 1'b1;
          if (sts_i.fl_done) state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sts_i.fl_any) begin
          state_d = S_IDLE;
        end else if (!sts_i.out_full || pop) begin
          cmd_o.fl_none = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

// File: hw/rtl/lru_writeback_block_cache_core.sv
// Get, put and invalidate: the request is captured, then executed in S_EXEC once
// the output register is free, which registers the result; one request at a time.
// Flush: S_FLUSH walks ranks from most recent, one rank per step while the output
// register is free, writing back each dirty entry up to the last; S_WAIT closes.
// Output register: results wait there until taken; a new result waits for it.
// Reset (rst_ni low, asynchronous): cache empty, marks and counters cleared.
module lru_writeback_block_cache_core
  import lwbc_pkg::*;
#(
  parameter int unsigned Entries   = DefEntries,
  parameter int unsigned DataWidth = DefDataWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [BlkW-1:0]    block_number_i,
  input  logic [InDataW-1:0] write_data_i,
  input  logic               dirty_flag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [InDataW-1:0] read_data_o,
  output logic [BlkW-1:0]    out_block_o,
  output logic               evicted_dirty_o,
  output logic               evicted_valid_o,
  output logic               last_o,
  output logic [31:0]        hit_total_o,
  output logic [31:0]        miss_total_o
);

  lwbc_cmd_t cmd;
  lwbc_sts_t sts;

  lwbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lwbc_datapath #(.Entries(Entries), .DataWidth(DataWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mode_i, .block_number_i, .write_data_i, .dirty_flag_i,
    .status_o, .read_data_o, .out_block_o, .evicted_dirty_o,
    .evicted_valid_o, .last_o, .hit_total_o, .miss_total_o
  );

endmodule

// File: hw/rtl/lwbc_checker.sv
module lwbc_checker
  import lwbc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic        last_o,
  input logic        evicted_valid_o,
  input logic        evicted_dirty_o,
  input logic [31:0] hit_total_o,
  input logic [31:0] miss_total_o
);

  // Held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped while stalled");

  // Only writebacks may be non-final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == ST_WB)
    else $error("non-final result that is not a writeback");

  // A dirty eviction is an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_dirty_o |-> evicted_valid_o)
    else $error("dirty eviction without eviction");

  // Counters never both move on one request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hit_total_o != $past(hit_total_o) && miss_total_o != $past(miss_total_o)))
    else $error("hit and miss counted together");

  // One request at a time: input closes right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken back to back");

endmodule

bind lru_writeback_block_cache_core lwbc_checker u_lwbc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .last_o, .evicted_valid_o, .evicted_dirty_o,
  .hit_total_o, .miss_total_o
);

// File: tb/tb_lru_writeback_block_cache_core.sv
`timescale 1ns / 100ps

// Scoreboard: mirrors the cache state and queues the results each request should produce
class lru_cache_scoreboard;
  localparam int NumSlots = 16;

  bit          slot_valid [NumSlots];
  bit [31:0]   slot_block [NumSlots];
  bit [63:0]   slot_data  [NumSlots];
  bit          slot_dirty [NumSlots];
  int          slot_rank  [NumSlots];
  bit [31:0]   hits;
  bit [31:0]   misses;
  bit [164:0]  expected_q [$];
  int          errors;
  int          checked;
  int          evictions;
  int          writebacks;

  function void clear();
    for (int i = 0; i < NumSlots; i++) begin
      slot_valid[i] = 0;
      slot_block[i] = '0;
      slot_data[i]  = '0;
      slot_dirty[i] = 0;
      slot_rank[i]  = 0;
    end
    hits = '0;
    misses = '0;
    expected_q.delete();
    errors = 0;
    checked = 0;
    evictions = 0;
    writebacks = 0;
  endfunction

  function int lookup(bit [31:0] blk);
    for (int i = 0; i < NumSlots; i++)
      if (slot_valid[i] && slot_block[i] == blk) return i;
    return -1;
  endfunction

  // Make slot s most recent, aging the more recent ones
  function void promote(int s);
    int r;
    r = slot_rank[s];
    for (int j = 0; j < NumSlots; j++)
      if (slot_valid[j] && j != s && slot_rank[j] < r) slot_rank[j]++;
    slot_rank[s] = 0;
  endfunction

  function void push(bit [1:0] st, bit [63:0] d, bit [31:0] b, bit ed, bit ev, bit lst);
    expected_q.push_back({st, d, b, ed, ev, lst, hits, misses});
  endfunction

  // Note an accepted request and predict its results
  function void note_request(bit [1:0] mode, bit [31:0] blk, bit [63:0] wdata, bit dflag);
    int s, f, n, oldest;
    s = lookup(blk);
    case (mode)
      lwbc_pkg::MODE_GET: begin
        if (s < 0) begin
          misses++;
          push(lwbc_pkg::ST_MISS, '0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          hits++;
          promote(s);
          push(lwbc_pkg::ST_DONE, slot_data[s], slot_block[s], 1'b0, 1'b0, 1'b1);
        end
      end
      lwbc_pkg::MODE_PUT: begin
        if (s >= 0) begin
          slot_data[s] = wdata;
          if (dflag) slot_dirty[s] = 1;
          promote(s);
          push(lwbc_pkg::ST_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          f = -1;
          for (int i = NumSlots - 1; i >= 0; i--)
            if (!slot_valid[i]) f = i;
          if (f >= 0) begin
            for (int i = 0; i < NumSlots; i++)
              if (slot_valid[i]) slot_rank[i]++;
            slot_valid[f] = 1;
            slot_rank[f]  = 0;
            slot_block[f] = blk;
            slot_data[f]  = wdata;
            slot_dirty[f] = dflag;
            push(lwbc_pkg::ST_DONE, '0, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            oldest = 0;
            for (int i = 1; i < NumSlots; i++)
              if (slot_rank[i] > slot_rank[oldest]) oldest = i;
            push(lwbc_pkg::ST_DONE, '0, slot_block[oldest], slot_dirty[oldest], 1'b1, 1'b1);
            evictions++;
            promote(oldest);
            slot_block[oldest] = blk;
            slot_data[oldest]  = wdata;
            slot_dirty[oldest] = dflag;
          end
        end
      end
      lwbc_pkg::MODE_INVAL: begin
        if (s < 0) begin
          push(lwbc_pkg::ST_MISS, '0, blk, 1'b0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < NumSlots; i++)
            if (slot_valid[i] && i != s && slot_rank[i] > slot_rank[s]) slot_rank[i]--;
          slot_valid[s] = 0;
          slot_dirty[s] = 0;
          slot_rank[s]  = 0;
          push(lwbc_pkg::ST_DONE, '0, blk, 1'b0, 1'b0, 1'b1);
        end
      end
      default: begin
        // Walk ranks from most recent, write back dirty slots
        n = 0;
        for (int r = 0; r < NumSlots; r++) begin
          for (int i = 0; i < NumSlots; i++) begin
            if (slot_valid[i] && slot_rank[i] == r) begin
              if (slot_dirty[i]) begin
                push(lwbc_pkg::ST_WB, slot_data[i], slot_block[i], 1'b0, 1'b0, 1'b0);
                slot_dirty[i] = 0;
                n++;
              end
              break;
            end
          end
        end
        writebacks += n;
        if (n == 0) push(lwbc_pkg::ST_NO_DIRTY, '0, '0, 1'b0, 1'b0, 1'b1);
        else expected_q[expected_q.size() - 1][64] = 1'b1;
      end
    endcase
  endfunction

  // Compare one result against the oldest expectation
  function void check_result(bit [1:0] st, bit [63:0] d, bit [31:0] b, bit ed, bit ev,
                             bit lst, bit [31:0] ht, bit [31:0] mt);
    bit [164:0] e;
    if (expected_q.size() == 0) begin
      $error("unexpected result: status %0d block %h", st, b);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (e[164:163] != st) begin
      $error("status: expected %0d actual %0d", e[164:163], st); errors++;
    end
    if (e[162:99] != d) begin
      $error("read_data: expected %h actual %h", e[162:99], d); errors++;
    end
    if (e[98:67] != b) begin
      $error("out_block: expected %h actual %h", e[98:67], b); errors++;
    end
    if (e[66] != ed) begin
      $error("evicted_dirty: expected %0d actual %0d", e[66], ed); errors++;
    end
    if (e[65] != ev) begin
      $error("evicted_valid: expected %0d actual %0d", e[65], ev); errors++;
    end
    if (e[64] != lst) begin
      $error("last: expected %0d actual %0d", e[64], lst); errors++;
    end
    if (e[63:32] != ht) begin
      $error("hit_total: expected %0d actual %0d", e[63:32], ht); errors++;
    end
    if (e[31:0] != mt) begin
      $error("miss_total: expected %0d actual %0d", e[31:0], mt); errors++;
    end
  endfunction
endclass

module tb_lru_writeback_block_cache_core;
  import lwbc_pkg::*;

  localparam int StallLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  mode_i;
  logic [31:0] block_number_i;
  logic [63:0] write_data_i;
  logic        dirty_flag_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [63:0] read_data_o;
  logic [31:0] out_block_o;
  logic        evicted_dirty_o;
  logic        evicted_valid_o;
  logic        last_o;
  logic [31:0] hit_total_o;
  logic [31:0] miss_total_o;

  lru_cache_scoreboard sb;
  bit          sender_calm;
  bit          receiver_calm;
  bit          hold_off;
  int          idle_cycles;
  int          requests_sent;
  bit [31:0]   block_pool [8];

  lru_writeback_block_cache_core dut (.*);

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one request and hold it until accepted, idling now and then
  task automatic send_request(bit [1:0] mode, bit [31:0] blk, bit [63:0] wdata, bit dflag);
    while (!sender_calm && $urandom_range(99) < 8) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    block_number_i <= blk;
    write_data_i   <= wdata;
    dirty_flag_i   <= dflag;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(mode, blk, wdata, dflag);
    requests_sent++;
  endtask

  // Pick a block from a small pool most of the time so hits and evictions occur
  function automatic bit [31:0] pick_block();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return block_pool[$urandom_range(7)] + $urandom_range(2);
    endcase
  endfunction

  function automatic bit [63:0] pick_data();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver: random stalls, plus one long hold-off
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) out_ready_i <= 1'b0;
      else out_ready_i <= receiver_calm || ($urandom_range(99) >= 8);
    end
  end

  // Check every result taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, read_data_o, out_block_o, evicted_dirty_o, evicted_valid_o,
                      last_o, hit_total_o, miss_total_o);
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else if (idle_cycles < StallLimit)
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("timeout: %0d results still expected", sb.expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    sb = new();
    sb.clear();
    in_valid_i     <= 1'b0;
    mode_i         <= MODE_GET;
    block_number_i <= '0;
    write_data_i   <= '0;
    dirty_flag_i   <= 1'b0;
    sender_calm    = 1'b0;
    receiver_calm  = 1'b0;
    hold_off       = 1'b0;
    idle_cycles    = 0;
    requests_sent  = 0;
    for (int i = 0; i < 8; i++) block_pool[i] = $urandom_range(1000) * 4;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty cache, extremes, dirty eviction, flush paths
    send_request(MODE_FLUSH, '0, '0, 1'b0);
    send_request(MODE_GET, 32'hFFFF_FFFF, '0, 1'b0);
    send_request(MODE_INVAL, 32'h1234, '0, 1'b0);
    send_request(MODE_PUT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_request(MODE_PUT, 32'h0, 64'h0, 1'b0);
    send_request(MODE_GET, 32'hFFFF_FFFF, '0, 1'b0);
    send_request(MODE_PUT, 32'h0, 64'hA5A5_0000_5A5A_FFFF, 1'b1);
    send_request(MODE_PUT, 32'h0, 64'h1, 1'b0);
    for (int i = 1; i <= 15; i++) send_request(MODE_PUT, 32'(i), pick_data(), i[0]);
    send_request(MODE_FLUSH, '0, '0, 1'b0);
    send_request(MODE_INVAL, 32'h5, '0, 1'b0);

    // Random: mostly puts and gets over a small pool of blocks
    for (int n = 0; n < 350; n++) begin
      sender_calm   = (n >= 100 && n < 160);
      receiver_calm = (n >= 100 && n < 160);
      if (n == 200) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7:
          send_request(MODE_PUT, pick_block(), pick_data(), 1'($urandom()));
        8, 9, 10, 11, 12, 13, 14:
          send_request(MODE_GET, pick_block(), pick_data(), 1'($urandom()));
        15, 16, 17:
          send_request(MODE_INVAL, pick_block(), pick_data(), 1'($urandom()));
        default:
          send_request(MODE_FLUSH, pick_block(), pick_data(), 1'($urandom()));
      endcase
    end
    in_valid_i <= 1'b0;

    // Drain, then let the pipeline settle
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d results: %0d hits, %0d misses,",
             requests_sent, sb.checked, sb.hits, sb.misses);
    $display("  %0d evictions on put and %0d flush writebacks.", sb.evictions, sb.writebacks);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/lwbc_pkg.sv
hw/rtl/lwbc_datapath.sv
hw/rtl/lwbc_ctrl.sv
hw/rtl/lru_writeback_block_cache_core.sv
hw/rtl/lwbc_checker.sv
tb/tb_lru_writeback_block_cache_core.sv
